@@ rtl/camera_frame_receiver_defines.svh @@
// Assertion macros shared by the camera frame receiver checkers.
// Each macro expects aclk and aresetn in scope of the module that uses it.
`ifndef CAMERA_FRAME_RECEIVER_DEFINES_SVH
`define CAMERA_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cfr check failed");

// Next-cycle implication, disabled while reset is asserted
`define CFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cfr check failed");

`endif

@@ rtl/cfr_pkg.sv @@
// Package for the camera frame receiver: protocol constants, mode and
// kind codes, and the result item types. No dependencies.
`default_nettype none

package cfr_pkg;

    // Frame format
    localparam int unsigned PAYLOAD_BYTES_DEF = 16;
    localparam logic [7:0]  HDR_FIRST         = 8'hAA;
    localparam logic [7:0]  HDR_SECOND        = 8'hAE;
    localparam logic [7:0]  TYPE_BLOCK        = 8'h21;
    localparam logic [7:0]  TYPE_LINE         = 8'h41;

    // Payload byte positions (low byte of each little-endian word)
    localparam int unsigned POS_TYPE      = 0;
    localparam int unsigned POS_BLK_STAT  = 1;
    localparam int unsigned POS_BLK_X     = 5;
    localparam int unsigned POS_BLK_Y     = 9;
    localparam int unsigned POS_LN_MARK   = 1;
    localparam int unsigned POS_LN_STAT   = 5;
    localparam int unsigned POS_LN_ANGLE  = 9;
    localparam int unsigned POS_LN_DEV    = 13;

    // Link watchdog
    localparam int unsigned TIMER_W     = 16;
    localparam logic [15:0] LIMIT_RESET = 16'd1000;

    // Item kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Mode codes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_BLOCK = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;

    // Stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 88;
    localparam int unsigned M_TUSER_W = 3;

    // Decoded frame fields, block_status in the lowest bits
    typedef struct packed {
        logic signed [15:0] line_deviation;
        logic signed [15:0] line_angle;
        logic [7:0]         line_status;
        logic [7:0]         line_marker;
        logic signed [15:0] block_y;
        logic signed [15:0] block_x;
        logic [7:0]         block_status;
    } cfr_frame_data_t;

    // One result item
    typedef struct packed {
        logic            frame_done;
        logic [1:0]      mode;
        logic            offline;
        cfr_frame_data_t data;
    } cfr_result_t;

endpackage

`default_nettype wire

@@ rtl/cfr_parser.sv @@
// Frame parser and link watchdog: header search, payload capture, decode
// and timer state. Depends on cfr_pkg.
`default_nettype none

module cfr_parser #(
    parameter int unsigned PAYLOAD_BYTES = cfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_valid,
    input  wire logic                kind,
    input  wire logic [7:0]          data_byte,
    input  wire logic [7:0]          elapsed_ms,
    input  wire logic [15:0]         limit_ms,
    output cfr_pkg::cfr_result_t     result
);
    import cfr_pkg::*;

    localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);

    // Receive phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HDR2 = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic                 offline_reg, offline_next;
    logic [1:0]           mode_reg, mode_next;
    cfr_frame_data_t      data_reg, data_next;
    logic [7:0]           store_reg [PAYLOAD_BYTES];
    logic [7:0]           view [PAYLOAD_BYTES];
    logic                 wr_en;
    logic                 frame_done;
    logic [TIMER_W:0]     timer_sum;
    logic [IDX_W-1:0]     wr_idx;

    assign wr_idx    = count_reg[IDX_W-1:0];
    assign timer_sum = {1'b0, timer_reg} + {{(TIMER_W - 8 + 1){1'b0}}, elapsed_ms};

    // Payload as seen including the byte being written this cycle
    always_comb begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            view[i] = (wr_en && wr_idx == IDX_W'(i)) ? data_byte : store_reg[i];
        end
    end

    // Next state for one item
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        timer_next   = timer_reg;
        offline_next = offline_reg;
        mode_next    = mode_reg;
        data_next    = data_reg;
        wr_en        = 1'b0;
        frame_done   = 1'b0;

        if (kind == KIND_TICK) begin
            if (timer_reg < limit_ms) begin
                timer_next = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];
            end else begin
                offline_next = 1'b1;
                mode_next    = MODE_NONE;
            end
        end else if (phase_reg == PH_IDLE && data_byte == HDR_FIRST) begin
            phase_next = PH_HDR2;
        end else if (phase_reg == PH_HDR2 && data_byte == HDR_SECOND) begin
            phase_next = PH_DATA;
            count_next = '0;
        end else if (phase_reg == PH_DATA) begin
            wr_en      = 1'b1;
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(PAYLOAD_BYTES - 1)) begin
                phase_next   = PH_IDLE;
                frame_done   = 1'b1;
                timer_next   = '0;
                offline_next = 1'b0;
                case (view[POS_TYPE])
                    TYPE_BLOCK: begin
                        data_next.block_status = view[POS_BLK_STAT];
                        data_next.block_x      = {view[POS_BLK_X + 1], view[POS_BLK_X]};
                        data_next.block_y      = {view[POS_BLK_Y + 1], view[POS_BLK_Y]};
                        mode_next              = MODE_BLOCK;
                    end
                    TYPE_LINE: begin
                        data_next.line_marker    = view[POS_LN_MARK];
                        data_next.line_status    = view[POS_LN_STAT];
                        data_next.line_angle     = {view[POS_LN_ANGLE + 1], view[POS_LN_ANGLE]};
                        data_next.line_deviation = {view[POS_LN_DEV + 1], view[POS_LN_DEV]};
                        mode_next                = MODE_LINE;
                    end
                    default: begin
                        // unknown type: frame counts, results untouched
                    end
                endcase
            end
        end else begin
            phase_next = PH_IDLE;
        end
    end

    // Control and result state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            timer_reg   <= '0;
            offline_reg <= 1'b0;
            mode_reg    <= MODE_NONE;
            data_reg    <= '0;
        end else if (item_valid) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            timer_reg   <= timer_next;
            offline_reg <= offline_next;
            mode_reg    <= mode_next;
            data_reg    <= data_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (item_valid && wr_en) begin
            store_reg[wr_idx] <= data_byte;
        end
    end

    assign result.frame_done = frame_done;
    assign result.mode       = mode_next;
    assign result.offline    = offline_next;
    assign result.data       = data_next;

endmodule

`default_nettype wire

@@ rtl/camera_frame_receiver.sv @@
// Camera frame receiver top level: stream ports, limit register and a
// two-entry output buffer around cfr_parser. Depends on cfr_pkg.
//
// Usage:
//   s_ channel: one item per handshake, either a received serial byte
//   (s_tuser = 0) or a millisecond tick (s_tuser = 1). Frames are 0xAA,
//   0xAE and PAYLOAD_BYTES payload bytes; type 0x21 updates block fields,
//   type 0x41 the line fields.
//   m_ channel: exactly one result item per input item, in order, holding
//   the offline flag, mode and all decoded fields; m_tlast marks the item
//   whose byte completed a frame.
//   cfg channel: writes offline_limit_ms; always ready. Write only while idle.
//   Results are registered: in the output register, or in the skid entry while m_ stalls.
//   Throughput: one item per cycle while s_tready is high; the parser state is registered per item.
//   Stall: an output register plus a skid entry hold up to two results;
//   s_tready falls only when both are full.
//   Reset: aresetn low clears the parser state, empties the output buffer
//   and loads the limit with 1000 ms.
`default_nettype none

module camera_frame_receiver #(
    parameter int unsigned PAYLOAD_BYTES = cfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [cfr_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte, [15:8] elapsed_ms
    input  wire logic [cfr_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] kind
    // result items
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [cfr_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] block_status, [23:8] block_x,
                                                            // [39:24] block_y, [47:40] line_marker,
                                                            // [55:48] line_status,
                                                            // [71:56] line_angle,
                                                            // [87:72] line_deviation
    output      logic [cfr_pkg::M_TUSER_W-1:0]   m_tuser,   // [0] offline, [2:1] mode
    output      logic                            m_tlast,   // frame_done
    // configuration
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [15:0]                     cfg_data   // offline_limit_ms
);
    import cfr_pkg::*;

    logic [15:0]  limit_reg;
    logic         s_accept;
    logic         m_drain;
    cfr_result_t  res_new;
    cfr_result_t  out_reg;
    cfr_result_t  skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;

    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_drain   = out_valid_reg && m_tready;
    assign cfg_ready = 1'b1;

    // Offline limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    cfr_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_accept),
        .kind       (s_tuser[0]),
        .data_byte  (s_tdata[7:0]),
        .elapsed_ms (s_tdata[15:8]),
        .limit_ms   (limit_reg),
        .result     (res_new)
    );

    // Output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_drain) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            if (!out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (m_drain) begin
            out_reg <= skid_valid_reg ? skid_reg : res_new;
        end else if (s_accept && !out_valid_reg) begin
            out_reg <= res_new;
        end
        if (s_accept && out_valid_reg && !m_drain) begin
            skid_reg <= res_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = {out_reg.mode, out_reg.offline};
    assign m_tlast  = out_reg.frame_done;

endmodule

`default_nettype wire

@@ rtl/cfr_checker.sv @@
// Port-level checker for camera_frame_receiver and its bind statement.
// Depends on cfr_pkg and camera_frame_receiver_defines.svh.
`default_nettype none
`include "camera_frame_receiver_defines.svh"

module cfr_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [cfr_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [cfr_pkg::M_TUSER_W-1:0]   m_tuser,
    input wire logic                            m_tlast
);
    import cfr_pkg::*;

    // mode code is never the unused value
    `CFR_ASSERT_IMP(a_mode_legal, m_tvalid, m_tuser[2:1] <= MODE_LINE)

    // an offline link reports no result mode
    `CFR_ASSERT_IMP(a_offline_no_mode, m_tvalid && m_tuser[0], m_tuser[2:1] == MODE_NONE)

    // a completed frame always brings the link back online
    `CFR_ASSERT_IMP(a_frame_online, m_tvalid && m_tlast, !m_tuser[0])

    // a stalled result item holds
    `CFR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind camera_frame_receiver cfr_checker u_cfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ bench/cfr_result_checker.sv @@
// Result checker for camera_frame_receiver: watches the input, result and
// limit channels, tracks the receiver state and compares every result item.
// Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_result_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [cfr_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte, [15:8] elapsed_ms
    input  wire logic [cfr_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] kind
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [cfr_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] block_status, [23:8] block_x,
                                                            // [39:24] block_y, [47:40] line_marker,
                                                            // [55:48] line_status,
                                                            // [71:56] line_angle,
                                                            // [87:72] line_deviation
    input  wire logic [cfr_pkg::M_TUSER_W-1:0]   m_tuser,   // [0] offline, [2:1] mode
    input  wire logic                            m_tlast,   // frame_done
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [15:0]                     cfg_data,  // offline_limit_ms
    output int                                   mismatch_count,
    output int                                   outstanding
);
    import cfr_pkg::*;

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_HDR2 = 2'd1,
        RX_DATA = 2'd2
    } rx_phase_e;

    // Tracked receiver state
    logic [15:0]     offline_limit;
    rx_phase_e       rx_phase;
    int unsigned     payload_count;
    logic [7:0]      payload [0:PAYLOAD_BYTES_DEF-1];
    logic [15:0]     link_timer;
    logic            offline_flag;
    logic [1:0]      mode_reg;
    cfr_frame_data_t frame_regs;

    // Results predicted but not yet seen on m_
    cfr_result_t pending_reports [$];

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    task automatic reset_tracker();
        offline_limit = LIMIT_RESET;
        rx_phase      = RX_IDLE;
        payload_count = 0;
        link_timer    = '0;
        offline_flag  = 1'b0;
        mode_reg      = MODE_NONE;
        frame_regs    = '0;
    endtask

    // Advance the tracked state by one input item, return the result item
    task automatic track_item(input logic kind, input logic [7:0] rx_byte,
                              input logic [7:0] elapsed, output cfr_result_t rpt);
        logic [16:0] sum;
        logic        done;
        done = 1'b0;
        if (kind == KIND_TICK) begin
            if (link_timer < offline_limit) begin
                sum = {1'b0, link_timer} + {9'd0, elapsed};
                link_timer = sum[16] ? 16'hFFFF : sum[15:0];
            end else begin
                offline_flag = 1'b1;
                mode_reg     = MODE_NONE;
            end
        end else if (rx_phase == RX_IDLE && rx_byte == HDR_FIRST) begin
            rx_phase = RX_HDR2;
        end else if (rx_phase == RX_HDR2 && rx_byte == HDR_SECOND) begin
            rx_phase      = RX_DATA;
            payload_count = 0;
        end else if (rx_phase == RX_DATA) begin
            payload[payload_count] = rx_byte;
            payload_count++;
            if (payload_count >= PAYLOAD_BYTES_DEF) begin
                rx_phase = RX_IDLE;
                done     = 1'b1;
                // decode by type byte; unknown types only refresh the link
                case (payload[POS_TYPE])
                    TYPE_BLOCK: begin
                        frame_regs.block_status = payload[POS_BLK_STAT];
                        frame_regs.block_x = {payload[POS_BLK_X+1], payload[POS_BLK_X]};
                        frame_regs.block_y = {payload[POS_BLK_Y+1], payload[POS_BLK_Y]};
                        mode_reg = MODE_BLOCK;
                    end
                    TYPE_LINE: begin
                        frame_regs.line_marker = payload[POS_LN_MARK];
                        frame_regs.line_status = payload[POS_LN_STAT];
                        frame_regs.line_angle = {payload[POS_LN_ANGLE+1], payload[POS_LN_ANGLE]};
                        frame_regs.line_deviation = {payload[POS_LN_DEV+1], payload[POS_LN_DEV]};
                        mode_reg = MODE_LINE;
                    end
                    default: ;
                endcase
                link_timer   = '0;
                offline_flag = 1'b0;
            end
        end else begin
            rx_phase = RX_IDLE;
        end
        rpt.offline    = offline_flag;
        rpt.mode       = mode_reg;
        rpt.data       = frame_regs;
        rpt.frame_done = done;
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch: expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    // Monitor all three channels at each rising edge
    always @(posedge aclk) begin : monitor
        cfr_result_t want;
        cfr_result_t got;
        if (!aresetn) begin
            reset_tracker();
            pending_reports.delete();
            outstanding = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                offline_limit = cfg_data;
            // results first: an item's result never leaves in its own cycle
            if (m_tvalid && m_tready) begin
                got.data       = m_tdata;
                got.offline    = m_tuser[0];
                got.mode       = m_tuser[2:1];
                got.frame_done = m_tlast;
                if (pending_reports.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result: expected none, actual %0h",
                             $time, got);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("offline", 16'(want.offline), 16'(got.offline));
                    check_field("mode", 16'(want.mode), 16'(got.mode));
                    check_field("block_status", 16'(want.data.block_status),
                                16'(got.data.block_status));
                    check_field("block_x", want.data.block_x, got.data.block_x);
                    check_field("block_y", want.data.block_y, got.data.block_y);
                    check_field("line_marker", 16'(want.data.line_marker),
                                16'(got.data.line_marker));
                    check_field("line_status", 16'(want.data.line_status),
                                16'(got.data.line_status));
                    check_field("line_angle", want.data.line_angle, got.data.line_angle);
                    check_field("line_deviation", want.data.line_deviation,
                                got.data.line_deviation);
                    check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
                end
            end
            if (s_tvalid && s_tready) begin
                track_item(s_tuser[0], s_tdata[7:0], s_tdata[15:8], want);
                pending_reports.push_back(want);
            end
            outstanding = pending_reports.size();
        end
    end

endmodule

@@ bench/camera_frame_receiver_tb.sv @@
// Top of the camera_frame_receiver bench: clock, reset, item stimulus with
// idling and back-pressure, limit writes and the verdict.
// Depends on cfr_pkg, camera_frame_receiver and cfr_result_checker.
`timescale 1ns / 1ps

module camera_frame_receiver_tb;
    import cfr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 180;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // [7:0] data_byte, [15:8] elapsed_ms
    logic [S_TUSER_W-1:0]   s_tuser = '0;   // [0] kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // decoded fields, block_status lowest
    logic [M_TUSER_W-1:0]   m_tuser;        // [0] offline, [2:1] mode
    logic                   m_tlast;        // frame_done
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [15:0]            cfg_data = '0;  // offline_limit_ms

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic [7:0] frame_bytes [0:PAYLOAD_BYTES_DEF-1];

    camera_frame_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    cfr_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_request) begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item and wait for its handshake; call at a rising edge
    task automatic send_item(input logic kind, input logic [7:0] rx_byte,
                             input logic [7:0] elapsed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {elapsed, rx_byte};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_tick();
        logic [7:0] elapsed;
        elapsed = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
        send_item(KIND_TICK, 8'($urandom_range(255)), elapsed);
    endtask

    // A serial byte, now and then preceded by a tick
    task automatic send_byte(input logic [7:0] rx_byte);
        if ($urandom_range(99) < 8)
            send_tick();
        send_item(KIND_BYTE, rx_byte, 8'($urandom_range(255)));
    endtask

    // Header, then the first len bytes of frame_bytes
    task automatic send_frame(input int len);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (int i = 0; i < len; i++)
            send_byte(frame_bytes[i]);
    endtask

    // Write the limit once everything in flight has come out
    task automatic write_limit(input logic [15:0] limit);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed frames with random content, some broken ones and noise
    task automatic run_random(input int count);
        int target;
        int sel;
        target = items_sent + count;
        while (items_sent < target) begin
            sel = $urandom_range(99);
            for (int i = 0; i < PAYLOAD_BYTES_DEF; i++)
                frame_bytes[i] = 8'($urandom_range(255));
            case ($urandom_range(9))
                0, 1, 2, 3: frame_bytes[POS_TYPE] = TYPE_BLOCK;
                4, 5, 6, 7: frame_bytes[POS_TYPE] = TYPE_LINE;
                default: ;
            endcase
            if (sel < 65) begin
                send_frame(PAYLOAD_BYTES_DEF);
            end else if (sel < 73) begin
                send_frame($urandom_range(PAYLOAD_BYTES_DEF - 1));
            end else if (sel < 82) begin
                // first header byte followed by something else
                send_byte(HDR_FIRST);
                send_byte(($urandom_range(1) == 0) ? HDR_FIRST : 8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    if ($urandom_range(1) == 0)
                        send_tick();
                    else
                        send_item(KIND_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle ticks, header errors, block frame with extreme fields
        send_item(KIND_TICK, 8'h00, 8'd0);
        send_item(KIND_TICK, 8'hFF, 8'd255);
        send_item(KIND_BYTE, HDR_FIRST, 8'h00);
        send_item(KIND_BYTE, HDR_FIRST, 8'hFF);   // repeated first header byte
        send_item(KIND_BYTE, HDR_SECOND, 8'h00);  // second header byte while idle
        send_item(KIND_BYTE, HDR_FIRST, 8'h00);
        send_item(KIND_BYTE, 8'h00, 8'hFF);       // wrong second header byte
        send_item(KIND_BYTE, 8'hFF, 8'h00);
        for (int i = 0; i < PAYLOAD_BYTES_DEF; i++)
            frame_bytes[i] = 8'($urandom_range(255));
        frame_bytes[POS_TYPE]      = TYPE_BLOCK;
        frame_bytes[POS_BLK_STAT]  = 8'hFF;
        frame_bytes[POS_BLK_X]     = 8'h00;
        frame_bytes[POS_BLK_X + 1] = 8'h80;
        frame_bytes[POS_BLK_Y]     = 8'hFF;
        frame_bytes[POS_BLK_Y + 1] = 8'h7F;
        send_item(KIND_BYTE, HDR_FIRST, 8'h00);
        send_item(KIND_BYTE, HDR_SECOND, 8'h00);
        for (int i = 0; i < PAYLOAD_BYTES_DEF; i++)
            send_item(KIND_BYTE, frame_bytes[i], 8'h00);

        // No idling, smallest limit: almost every tick takes the link offline
        write_limit(16'd1);
        run_random(PHASE_ITEMS);

        // Sender idle most of the time, limit of 65000
        write_limit(16'd65000);
        send_idle_pct = 72;
        run_random(PHASE_ITEMS);

        // Receiver stalling most of the time, random limit
        write_limit(16'($urandom_range(65000, 1)));
        send_idle_pct = 0;
        recv_idle_pct = 72;
        run_random(PHASE_ITEMS);

        // Both sides idling a little
        write_limit(16'd300);
        send_idle_pct = 13;
        recv_idle_pct = 13;
        run_random(PHASE_ITEMS);

        // Long receiver hold-offs while the sender keeps offering
        write_limit(LIMIT_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request++;
        run_random(PHASE_ITEMS / 2);
        hold_request++;
        run_random(PHASE_ITEMS / 2);

        // Drain and give the verdict
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cfr_pkg.sv
rtl/cfr_parser.sv
rtl/camera_frame_receiver.sv
rtl/cfr_checker.sv
bench/cfr_result_checker.sv
bench/camera_frame_receiver_tb.sv
